// ===== rtl/core/glss_pkg.sv =====
// Shared types, constants and codes for the doubly applied Laplacian stencil block.
package glss_pkg;

   // Largest grid extents along each axis.
   localparam int MAX_X = 64;
   localparam int MAX_Y = 64;
   localparam int MAX_Z = 64;

   // Field and register widths.
   localparam int DATA_W  = 32;
   localparam int SIZE_W  = 7;
   localparam int CSR_IW  = 8;
   localparam int PLANE_W = $clog2(MAX_X * MAX_Y + 1);
   localparam int POS_W   = $clog2(MAX_X * MAX_Y * MAX_Z + 1);
   // Circular stores must hold two planes plus one point; rounded up to a power of two.
   localparam int STORE_AW = $clog2(2 * MAX_X * MAX_Y + 1);
   localparam int STORE_D  = 1 << STORE_AW;

   // Arithmetic widths: neighbor sum, product and accumulator.
   localparam int DIFF_W = DATA_W + 3;
   localparam int PROD_W = DIFF_W + DATA_W + 1;
   localparam int ACC_W  = PROD_W + 2;

   // Configuration register indexes.
   localparam logic [CSR_IW-1:0] CSR_MODE = 8'd0;
   localparam logic [CSR_IW-1:0] CSR_XSZ  = 8'd1;
   localparam logic [CSR_IW-1:0] CSR_YSZ  = 8'd2;
   localparam logic [CSR_IW-1:0] CSR_ZSZ  = 8'd3;
   localparam logic [CSR_IW-1:0] CSR_WX   = 8'd4;
   localparam logic [CSR_IW-1:0] CSR_WY   = 8'd5;
   localparam logic [CSR_IW-1:0] CSR_WZ   = 8'd6;

   // Stencil taps in the order they are read.
   typedef enum logic [2:0] {
      TAP_C, TAP_XM, TAP_XP, TAP_YM, TAP_YP, TAP_ZM, TAP_ZP
   } tap_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_RD, ST_USE, ST_MAC, ST_FIN
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic    accept;
      logic    clear_acc;
      logic    use_mid;
      tap_type tap;
      logic    capture;
      logic    mac;
      logic    mid_write;
      logic    out_load;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic geom_ok;
      logic pending;
      logic mid_needed;
      logic rsp_busy;
      logic three_dim;
   } status_type;

endpackage

// ===== rtl/core/glss_ctrl.sv =====
// Sequencing controller for the two stencil passes.
module glss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  glss_pkg::status_type status,
   output glss_pkg::cmd_type    cmd
);

   glss_pkg::state_type state_ff, state_in;
   glss_pkg::tap_type   tap_ff, tap_in;
   logic                mid_ff, mid_in;
   logic                last_tap;

   // The stencil ends after the y pair in 2D and after the z pair in 3D.
   assign last_tap = (tap_ff == glss_pkg::TAP_ZP) ||
                     (tap_ff == glss_pkg::TAP_YP && !status.three_dim);

   // Next state.
   always_comb begin
      state_in = state_ff;
      tap_in   = tap_ff;
      mid_in   = mid_ff;
      case (state_ff)
         glss_pkg::ST_IDLE: begin
            if (req_valid && status.geom_ok) state_in = glss_pkg::ST_CHECK;
         end
         glss_pkg::ST_CHECK: begin
            if (status.pending) begin
               mid_in   = status.mid_needed;
               tap_in   = glss_pkg::TAP_C;
               state_in = glss_pkg::ST_RD;
            end else begin
               state_in = glss_pkg::ST_IDLE;
            end
         end
         glss_pkg::ST_RD: state_in = glss_pkg::ST_USE;
         glss_pkg::ST_USE: begin
            if (tap_ff inside {glss_pkg::TAP_XP, glss_pkg::TAP_YP, glss_pkg::TAP_ZP}) begin
               state_in = glss_pkg::ST_MAC;
            end else begin
               tap_in   = glss_pkg::tap_type'(tap_ff + 3'd1);
               state_in = glss_pkg::ST_RD;
            end
         end
         glss_pkg::ST_MAC: begin
            if (last_tap) begin
               state_in = glss_pkg::ST_FIN;
            end else begin
               tap_in   = glss_pkg::tap_type'(tap_ff + 3'd1);
               state_in = glss_pkg::ST_RD;
            end
         end
         glss_pkg::ST_FIN: begin
            if (mid_ff) state_in = glss_pkg::ST_CHECK;
            else if (!status.rsp_busy) state_in = glss_pkg::ST_IDLE;
         end
         default: state_in = glss_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready     = (state_ff == glss_pkg::ST_IDLE) && status.geom_ok;
      cmd.accept    = req_ready && req_valid;
      cmd.clear_acc = (state_ff == glss_pkg::ST_CHECK);
      cmd.use_mid   = !mid_ff;
      cmd.tap       = tap_ff;
      cmd.capture   = (state_ff == glss_pkg::ST_USE);
      cmd.mac       = (state_ff == glss_pkg::ST_MAC);
      cmd.mid_write = (state_ff == glss_pkg::ST_FIN) && mid_ff;
      cmd.out_load  = (state_ff == glss_pkg::ST_FIN) && !mid_ff && !status.rsp_busy;
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= glss_pkg::ST_IDLE;
         tap_ff   <= glss_pkg::TAP_C;
         mid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         mid_ff   <= mid_in;
      end
   end

endmodule

// ===== rtl/core/glss_dpath.sv =====
// Datapath: configuration, positions, plane stores and stencil arithmetic.
module glss_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [glss_pkg::CSR_IW-1:0]        csr_index,
   input  logic [glss_pkg::DATA_W-1:0]        csr_wdata,
   input  logic signed [glss_pkg::DATA_W-1:0] req_sample,
   input  logic                               req_is_drain,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [glss_pkg::DATA_W-1:0] rsp_result,
   output logic                               rsp_last_point,
   output logic                               rsp_saturated,
   input  glss_pkg::cmd_type                  cmd,
   output glss_pkg::status_type               status
);

   localparam int SW = glss_pkg::SIZE_W;
   localparam int PW = glss_pkg::POS_W;
   localparam int AW = glss_pkg::STORE_AW;
   localparam int DW = glss_pkg::DATA_W;

   // Configuration registers.
   logic          mode_ff;
   logic [SW-1:0] xsz_ff, ysz_ff, zsz_ff;
   logic [DW-1:0] wx_ff, wy_ff, wz_ff;
   logic          csr_hit;

   assign csr_hit = csr_we && (csr_index <= glss_pkg::CSR_WZ);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         xsz_ff  <= SW'(64);
         ysz_ff  <= SW'(64);
         zsz_ff  <= SW'(1);
         wx_ff   <= DW'(65536);
         wy_ff   <= DW'(65536);
         wz_ff   <= DW'(65536);
      end else if (csr_we) begin
         case (csr_index)
            glss_pkg::CSR_MODE: mode_ff <= csr_wdata[0];
            glss_pkg::CSR_XSZ:  xsz_ff  <= csr_wdata[SW-1:0];
            glss_pkg::CSR_YSZ:  ysz_ff  <= csr_wdata[SW-1:0];
            glss_pkg::CSR_ZSZ:  zsz_ff  <= csr_wdata[SW-1:0];
            glss_pkg::CSR_WX:   wx_ff   <= csr_wdata;
            glss_pkg::CSR_WY:   wy_ff   <= csr_wdata;
            glss_pkg::CSR_WZ:   wz_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamped extents; z counts as one in 2D.
   logic [SW-1:0] nx, ny, nz;
   always_comb begin
      nx = (xsz_ff == '0) ? SW'(1) : (xsz_ff > SW'(glss_pkg::MAX_X)) ? SW'(glss_pkg::MAX_X) : xsz_ff;
      ny = (ysz_ff == '0) ? SW'(1) : (ysz_ff > SW'(glss_pkg::MAX_Y)) ? SW'(glss_pkg::MAX_Y) : ysz_ff;
      nz = !mode_ff ? SW'(1) :
           (zsz_ff == '0) ? SW'(1) : (zsz_ff > SW'(glss_pkg::MAX_Z)) ? SW'(glss_pkg::MAX_Z) : zsz_ff;
   end

   // Two-stage geometry products, held as unsettled after reset or any register write.
   logic [glss_pkg::PLANE_W-1:0] plane_ff, reach_ff;
   logic [PW-1:0]                total_ff;
   logic [1:0]                   settle_ff;

   always_ff @(posedge clock) begin
      plane_ff <= glss_pkg::PLANE_W'(nx) * glss_pkg::PLANE_W'(ny);
      total_ff <= PW'(plane_ff) * PW'(nz);
      reach_ff <= mode_ff ? plane_ff : glss_pkg::PLANE_W'(nx);
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) settle_ff <= 2'd2;
      else if (settle_ff != 2'd0) settle_ff <= settle_ff - 2'd1;
   end

   // Grid positions and coordinates of the middle and output points.
   logic [PW-1:0] in_pos_ff, mid_pos_ff, out_pos_ff;
   logic [SW-1:0] mi_ff, mj_ff, mk_ff, oi_ff, oj_ff, ok_ff;
   logic          out_last, grid_end;

   assign out_last = (out_pos_ff == total_ff - PW'(1));
   assign grid_end = cmd.out_load && out_last;

   always_ff @(posedge clock) begin
      if (reset || csr_hit || grid_end) begin
         in_pos_ff  <= '0;
         mid_pos_ff <= '0;
         out_pos_ff <= '0;
         mi_ff <= '0; mj_ff <= '0; mk_ff <= '0;
         oi_ff <= '0; oj_ff <= '0; ok_ff <= '0;
      end else begin
         if (cmd.accept && !req_is_drain && in_pos_ff < total_ff) in_pos_ff <= in_pos_ff + PW'(1);
         if (cmd.mid_write) begin
            mid_pos_ff <= mid_pos_ff + PW'(1);
            if (mi_ff + SW'(1) == nx) begin
               mi_ff <= '0;
               if (mj_ff + SW'(1) == ny) begin
                  mj_ff <= '0;
                  mk_ff <= mk_ff + SW'(1);
               end else begin
                  mj_ff <= mj_ff + SW'(1);
               end
            end else begin
               mi_ff <= mi_ff + SW'(1);
            end
         end
         if (cmd.out_load) begin
            out_pos_ff <= out_pos_ff + PW'(1);
            if (oi_ff + SW'(1) == nx) begin
               oi_ff <= '0;
               if (oj_ff + SW'(1) == ny) begin
                  oj_ff <= '0;
                  ok_ff <= ok_ff + SW'(1);
               end else begin
                  oj_ff <= oj_ff + SW'(1);
               end
            end else begin
               oi_ff <= oi_ff + SW'(1);
            end
         end
      end
   end

   // Readiness of the next result and of the next middle value.
   logic [PW:0] need, target;
   always_comb begin
      need   = {1'b0, out_pos_ff} + {{(PW - glss_pkg::PLANE_W){1'b0}}, reach_ff, 1'b0}
               + (PW + 1)'(1);
      if (need > {1'b0, total_ff}) need = {1'b0, total_ff};
      target = {1'b0, out_pos_ff} + (PW + 1)'(reach_ff);
      if (target > {1'b0, total_ff - PW'(1)}) target = {1'b0, total_ff - PW'(1)};
   end

   assign status.geom_ok    = (settle_ff == 2'd0);
   assign status.pending    = (out_pos_ff < total_ff) && ({1'b0, in_pos_ff} >= need);
   assign status.mid_needed = ({1'b0, mid_pos_ff} <= target);
   assign status.rsp_busy   = rsp_valid && !rsp_ready;
   assign status.three_dim  = mode_ff;

   // Neighbor address of the current tap, clamped at the grid faces.
   logic [PW-1:0] pt;
   logic [SW-1:0] ci, cj, ck;
   logic [PW-1:0] taddr;
   always_comb begin
      pt = cmd.use_mid ? out_pos_ff : mid_pos_ff;
      ci = cmd.use_mid ? oi_ff : mi_ff;
      cj = cmd.use_mid ? oj_ff : mj_ff;
      ck = cmd.use_mid ? ok_ff : mk_ff;
      taddr = pt;
      case (cmd.tap)
         glss_pkg::TAP_XM: if (ci != '0) taddr = pt - PW'(1);
         glss_pkg::TAP_XP: if (ci + SW'(1) < nx) taddr = pt + PW'(1);
         glss_pkg::TAP_YM: if (cj != '0) taddr = pt - PW'(nx);
         glss_pkg::TAP_YP: if (cj + SW'(1) < ny) taddr = pt + PW'(nx);
         glss_pkg::TAP_ZM: if (ck != '0) taddr = pt - PW'(plane_ff);
         glss_pkg::TAP_ZP: if (ck + SW'(1) < nz) taddr = pt + PW'(plane_ff);
         default: taddr = pt;
      endcase
   end

   // Circular plane stores: samples, and first-pass values with a clip bit.
   logic [DW-1:0] in_mem  [glss_pkg::STORE_D];
   logic [DW:0]   mid_mem [glss_pkg::STORE_D];
   logic [DW-1:0] in_rd_ff;
   logic [DW:0]   mid_rd_ff;
   logic [DW-1:0] fin_val;
   logic          fin_clip;

   always_ff @(posedge clock) begin
      if (cmd.accept && !req_is_drain && in_pos_ff < total_ff) in_mem[in_pos_ff[AW-1:0]] <= req_sample;
      in_rd_ff <= in_mem[taddr[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.mid_write) mid_mem[mid_pos_ff[AW-1:0]] <= {fin_clip, fin_val};
      mid_rd_ff <= mid_mem[taddr[AW-1:0]];
   end

   // Per-axis term: weight times (minus + plus - 2 * center).
   logic signed [DW-1:0]                  rdata;
   logic                                  rflag;
   logic signed [DW-1:0]                  c_ff, a_ff;
   logic signed [glss_pkg::DIFF_W-1:0]    diff;
   logic [DW-1:0]                         wsel;
   logic signed [glss_pkg::PROD_W-1:0]    prod_ff;
   logic signed [glss_pkg::ACC_W-1:0]     acc_ff;
   logic                                  clip_ff;

   assign rdata = cmd.use_mid ? mid_rd_ff[DW-1:0] : in_rd_ff;
   assign rflag = cmd.use_mid && mid_rd_ff[DW];
   assign diff  = glss_pkg::DIFF_W'(a_ff) + glss_pkg::DIFF_W'(rdata)
                  - (glss_pkg::DIFF_W'(c_ff) <<< 1);
   always_comb begin
      case (cmd.tap)
         glss_pkg::TAP_YP: wsel = wy_ff;
         glss_pkg::TAP_ZP: wsel = wz_ff;
         default:          wsel = wx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         case (cmd.tap)
            glss_pkg::TAP_C: c_ff <= rdata;
            glss_pkg::TAP_XP, glss_pkg::TAP_YP, glss_pkg::TAP_ZP:
               prod_ff <= diff * $signed({1'b0, wsel});
            default: a_ff <= rdata;
         endcase
      end
   end

   // Accumulator and sticky clip flag over one stencil.
   always_ff @(posedge clock) begin
      if (cmd.clear_acc) begin
         acc_ff  <= '0;
         clip_ff <= 1'b0;
      end else begin
         if (cmd.mac) acc_ff <= acc_ff + glss_pkg::ACC_W'(prod_ff);
         if (cmd.capture && rflag) clip_ff <= 1'b1;
      end
   end

   // Round half up back to Q16.16 and saturate to 32 bits.
   logic signed [glss_pkg::ACC_W-1:0] rnd;
   logic [glss_pkg::ACC_W-17:0]       shv;
   logic                              in_range;
   always_comb begin
      rnd      = acc_ff + glss_pkg::ACC_W'(32768);
      shv      = rnd[glss_pkg::ACC_W-1:16];
      in_range = (shv[glss_pkg::ACC_W-17:DW-1] == '0) || (shv[glss_pkg::ACC_W-17:DW-1] == '1);
      if (in_range) fin_val = shv[DW-1:0];
      else fin_val = rnd[glss_pkg::ACC_W-1] ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
      fin_clip = clip_ff || !in_range;
   end

   // Result register, parting the stencil engine from the result channel.
   logic rsp_valid_ff;
   logic signed [DW-1:0] rsp_result_ff;
   logic rsp_last_ff, rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_result_ff <= fin_val;
         rsp_last_ff   <= out_last;
         rsp_sat_ff    <= fin_clip;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result     = rsp_result_ff;
   assign rsp_last_point = rsp_last_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule

// ===== rtl/core/grid_laplacian_squared_stencil.sv =====
// Top level: doubly applied Laplacian over a raster grid stream.
//
//   Port group | Direction | Handshake           | Payload
//   req_*      | in        | req_valid/req_ready | req_sample, req_is_drain
//   rsp_*      | out       | rsp_valid/rsp_ready | rsp_result, rsp_last_point, rsp_saturated
//   csr_*      | in        | csr_we              | csr_index, csr_wdata
//
// An item that yields no result only passes the check state; one that yields a result
// computes the first-pass values it needs and then its output stencil, reading each tap
// in a read state and then a use state, since each plane store has one read port.
// Reset is synchronous; geometry settles anew after reset or any register write.
// A result waits in the output register while the next item is taken in; a stalled
// result channel holds the engine only when the following result is ready.
module grid_laplacian_squared_stencil (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [glss_pkg::DATA_W-1:0]  req_sample,
   input  logic                                req_is_drain,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [glss_pkg::DATA_W-1:0]  rsp_result,
   output logic                                rsp_last_point,
   output logic                                rsp_saturated,
   input  logic                                csr_we,
   input  logic [glss_pkg::CSR_IW-1:0]         csr_index,
   input  logic [glss_pkg::DATA_W-1:0]         csr_wdata
);

   glss_pkg::cmd_type    cmd;
   glss_pkg::status_type status;

   glss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   glss_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_sample     (req_sample),
      .req_is_drain   (req_is_drain),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_result     (rsp_result),
      .rsp_last_point (rsp_last_point),
      .rsp_saturated  (rsp_saturated),
      .cmd            (cmd),
      .status         (status)
   );

   // A result is loaded only into a free output register.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over an unsent transaction");

   // A register write holds off input transactions while the geometry settles.
   assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !req_ready)
      else $error("input taken before geometry settled");

   // A newly loaded result is presented on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("loaded result not presented");

endmodule

// ===== tb/sv/glss_checker.sv =====
// Checker for the stencil block: watches all ports, predicts results and compares them.
`timescale 1ns / 1ps

module glss_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_sample,
   input  logic        req_is_drain,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_result,
   input  logic        rsp_last_point,
   input  logic        rsp_saturated,
   input  logic        csr_we,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          grids_done,
   output int          results_seen,
   output int          sat_seen
);

   localparam int DEPTH = 2 * glss_pkg::MAX_X * glss_pkg::MAX_Y + 1;

   typedef struct packed {
      logic [31:0] result;
      logic        last_point;
      logic        saturated;
   } point_result_type;

   // Shadow copy of the configuration registers.
   logic        mode_3d;
   logic [6:0]  size_x, size_y, size_z;
   logic [31:0] wgt_x, wgt_y, wgt_z;

   // Shadow copy of the plane stores and grid positions.
   logic [31:0] sample_plane [DEPTH];
   logic [31:0] lap_plane [DEPTH];
   bit          lap_clip [DEPTH];
   int unsigned in_pos, mid_pos, out_pos;
   int unsigned g_nx, g_ny, g_nz, g_total, g_reach;

   point_result_type expected_points [$];

   function automatic int unsigned clamp_axis(logic [6:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic void update_geometry();
      g_nx = clamp_axis(size_x, glss_pkg::MAX_X);
      g_ny = clamp_axis(size_y, glss_pkg::MAX_Y);
      g_nz = mode_3d ? clamp_axis(size_z, glss_pkg::MAX_Z) : 1;
      g_total = g_nx * g_ny * g_nz;
      g_reach = mode_3d ? g_nx * g_ny : g_nx;
   endfunction

   function automatic longint fetch_tap(bit from_mid, int unsigned idx, inout bit clip);
      int unsigned a;
      a = idx % DEPTH;
      if (from_mid) begin
         if (lap_clip[a]) clip = 1;
         return longint'($signed(lap_plane[a]));
      end
      return longint'($signed(sample_plane[a]));
   endfunction

   // One Laplacian pass at point p over the sample or the first-pass plane.
   function automatic logic [31:0] laplacian_at(bit from_mid, int unsigned p, inout bit clip);
      logic signed [127:0] acc, term;
      longint c, lo, hi;
      int unsigned plane, i, j, k;
      plane = g_nx * g_ny;
      i = p % g_nx;
      j = (p / g_nx) % g_ny;
      k = p / plane;
      acc = 0;
      c = fetch_tap(from_mid, p, clip);
      lo = fetch_tap(from_mid, i > 0 ? p - 1 : p, clip);
      hi = fetch_tap(from_mid, i + 1 < g_nx ? p + 1 : p, clip);
      term = lo + hi - 2 * c;
      acc += term * $signed({96'd0, wgt_x});
      lo = fetch_tap(from_mid, j > 0 ? p - g_nx : p, clip);
      hi = fetch_tap(from_mid, j + 1 < g_ny ? p + g_nx : p, clip);
      term = lo + hi - 2 * c;
      acc += term * $signed({96'd0, wgt_y});
      if (mode_3d) begin
         lo = fetch_tap(from_mid, k > 0 ? p - plane : p, clip);
         hi = fetch_tap(from_mid, k + 1 < g_nz ? p + plane : p, clip);
         term = lo + hi - 2 * c;
         acc += term * $signed({96'd0, wgt_z});
      end
      // Round half up back to Q16.16, then clip to 32 bits.
      acc = (acc + 128'sd32768) >>> 16;
      if (acc > 128'sd2147483647) begin
         clip = 1;
         return 32'h7FFF_FFFF;
      end
      if (acc < -128'sd2147483648) begin
         clip = 1;
         return 32'h8000_0000;
      end
      return acc[31:0];
   endfunction

   // Advance the predicted grid by one request; returns 1 when a result is due.
   function automatic bit predict_point(logic [31:0] smp, logic drain,
                                        output point_result_type r);
      int unsigned need, target, q;
      bit clip, c1;
      clip = 0;
      r = '0;
      update_geometry();
      if (!drain && in_pos < g_total) begin
         sample_plane[in_pos % DEPTH] = smp;
         in_pos++;
      end
      if (out_pos >= g_total) return 0;
      q = out_pos;
      need = q + 2 * g_reach + 1;
      if (need > g_total) need = g_total;
      if (in_pos < need) return 0;
      target = q + g_reach;
      if (target > g_total - 1) target = g_total - 1;
      while (mid_pos <= target) begin
         c1 = 0;
         lap_plane[mid_pos % DEPTH] = laplacian_at(0, mid_pos, c1);
         lap_clip[mid_pos % DEPTH] = c1;
         mid_pos++;
      end
      r.result = laplacian_at(1, q, clip);
      r.last_point = (q == g_total - 1);
      r.saturated = clip;
      out_pos++;
      if (r.last_point) begin
         in_pos = 0;
         mid_pos = 0;
         out_pos = 0;
      end
      return 1;
   endfunction

   always @(posedge clock) begin
      point_result_type exp_r, got_r;
      if (reset) begin
         mode_3d = 0;
         size_x = 64;
         size_y = 64;
         size_z = 1;
         wgt_x = 32'h0001_0000;
         wgt_y = 32'h0001_0000;
         wgt_z = 32'h0001_0000;
         in_pos = 0;
         mid_pos = 0;
         out_pos = 0;
         expected_points.delete();
         fail_count <= 0;
         grids_done <= 0;
         results_seen <= 0;
         sat_seen <= 0;
      end else begin
         // A write to a listed register aborts the current grid.
         if (csr_we && csr_index <= glss_pkg::CSR_WZ) begin
            case (csr_index)
               glss_pkg::CSR_MODE: mode_3d = csr_wdata[0];
               glss_pkg::CSR_XSZ:  size_x = csr_wdata[6:0];
               glss_pkg::CSR_YSZ:  size_y = csr_wdata[6:0];
               glss_pkg::CSR_ZSZ:  size_z = csr_wdata[6:0];
               glss_pkg::CSR_WX:   wgt_x = csr_wdata;
               glss_pkg::CSR_WY:   wgt_y = csr_wdata;
               default:            wgt_z = csr_wdata;
            endcase
            in_pos = 0;
            mid_pos = 0;
            out_pos = 0;
         end
         // Compare a result transaction with the oldest expectation.
         if (rsp_valid && rsp_ready) begin
            got_r = {rsp_result, rsp_last_point, rsp_saturated};
            results_seen <= results_seen + 1;
            if (rsp_last_point) grids_done <= grids_done + 1;
            if (rsp_saturated) sat_seen <= sat_seen + 1;
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h/%b/%b", $time,
                        rsp_result, rsp_last_point, rsp_saturated);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_points.pop_front();
               if (got_r != exp_r) begin
                  $display("%0t: result mismatch, expected %h/%b/%b, actual %h/%b/%b",
                           $time, exp_r.result, exp_r.last_point, exp_r.saturated,
                           got_r.result, got_r.last_point, got_r.saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // Predict the effect of a request transaction.
         if (req_valid && req_ready) begin
            if (predict_point(req_sample, req_is_drain, exp_r)) expected_points.push_back(exp_r);
         end
      end
      pending <= expected_points.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top: clock, reset, stimulus for the stencil block and the final verdict.
`timescale 1ns / 1ps

module tb_top;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic signed [glss_pkg::DATA_W-1:0]  req_sample;
   logic                                req_is_drain;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic signed [glss_pkg::DATA_W-1:0]  rsp_result;
   logic                                rsp_last_point;
   logic                                rsp_saturated;
   logic                                csr_we;
   logic [glss_pkg::CSR_IW-1:0]         csr_index;
   logic [glss_pkg::DATA_W-1:0]         csr_wdata;

   int  fail_count, pending, grids_done, results_seen, sat_seen;
   int  items_sent;
   bit  idle_on;
   int  stall_left;
   // Grid geometry as the stimulus sees it.
   bit          cur_3d;
   int unsigned cur_x, cur_y, cur_z;

   grid_laplacian_squared_stencil dut (.*);

   glss_checker u_checker (
      .clock, .reset, .req_valid, .req_ready, .req_sample, .req_is_drain,
      .rsp_valid, .rsp_ready, .rsp_result, .rsp_last_point, .rsp_saturated,
      .csr_we, .csr_index, .csr_wdata,
      .fail_count, .pending, .grids_done, .results_seen, .sat_seen
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Result side: random stall bursts while idling is enabled.
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         rsp_ready <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
      end
   end

   function automatic int unsigned axis_points(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_weight();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(0, 32'h4_0000);
      endcase
   endfunction

   // One request transaction, with an optional idle burst ahead of it.
   task automatic send_request(logic [31:0] smp, logic drain);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1;
      req_sample <= smp;
      req_is_drain <= drain;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic end_requests();
      req_valid <= 0;
      @(posedge clock);
   endtask

   // Register writes happen only with no result outstanding and the engine quiet.
   // The caller drops the write enable after the last write of a sequence.
   task automatic write_csr(logic [glss_pkg::CSR_IW-1:0] idx, logic [31:0] data);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         glss_pkg::CSR_MODE: cur_3d = data[0];
         glss_pkg::CSR_XSZ:  cur_x = data[6:0];
         glss_pkg::CSR_YSZ:  cur_y = data[6:0];
         glss_pkg::CSR_ZSZ:  cur_z = data[6:0];
         default: ;
      endcase
   endtask

   task automatic configure(bit m, int unsigned x, int unsigned y, int unsigned z,
                            logic [31:0] wx, logic [31:0] wy, logic [31:0] wz);
      end_requests();
      wait (pending == 0);
      repeat (40) @(posedge clock);
      // Upper bits of the size registers carry random junk.
      write_csr(glss_pkg::CSR_MODE, {$urandom} & 32'hFFFF_FFFE | m);
      write_csr(glss_pkg::CSR_XSZ, {$urandom} & 32'hFFFF_FF80 | x);
      write_csr(glss_pkg::CSR_YSZ, {$urandom} & 32'hFFFF_FF80 | y);
      write_csr(glss_pkg::CSR_ZSZ, {$urandom} & 32'hFFFF_FF80 | z);
      write_csr(glss_pkg::CSR_WX, wx);
      write_csr(glss_pkg::CSR_WY, wy);
      write_csr(glss_pkg::CSR_WZ, wz);
      // An index beyond the register list must be ignored.
      write_csr(glss_pkg::CSR_IW'(glss_pkg::CSR_WZ + 1 + $urandom_range(0, 248)), $urandom);
      csr_we <= 0;
      repeat (4) @(posedge clock);
   endtask

   // Stream one grid with noise drains, then flush until its last point arrives.
   task automatic run_grid(int noise_pct);
      int unsigned nx, ny, nz, total, reach, early, left;
      int start;
      nx = axis_points(cur_x, glss_pkg::MAX_X);
      ny = axis_points(cur_y, glss_pkg::MAX_Y);
      nz = cur_3d ? axis_points(cur_z, glss_pkg::MAX_Z) : 1;
      total = nx * ny * nz;
      reach = cur_3d ? nx * ny : nx;
      early = (total > 2 * reach + 1) ? total - 1 - 2 * reach : 0;
      left = total - early - 1;
      start = grids_done;
      for (int unsigned n = 0; n < total; n++) begin
         if ($urandom_range(0, 99) < noise_pct) send_request($urandom, 1);
         send_request(pick_sample(), 0);
      end
      // A sample after the grid's end is discarded while results are still pending.
      if (left >= 2 && $urandom_range(0, 1)) send_request($urandom, 0);
      while (grids_done == start) begin
         send_request($urandom, 1);
      end
   endtask

   initial begin
      int unsigned rx, ry, rz;
      bit rm;
      reset = 1;
      req_valid = 0;
      req_sample = 0;
      req_is_drain = 0;
      csr_we = 0;
      csr_index = 0;
      csr_wdata = 0;
      items_sent = 0;
      idle_on = 0;
      cur_3d = 0;
      cur_x = 64;
      cur_y = 64;
      cur_z = 1;
      repeat (6) @(posedge clock);
      reset <= 0;
      repeat (4) @(posedge clock);

      // Directed: size extremes, zero sizes, extreme weights.
      configure(0, 3, 2, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_request(0, 1);
      send_request(32'h7FFF_FFFF, 0);
      send_request(32'h8000_0000, 0);
      send_request(32'hFFFF_FFFF, 0);
      send_request(32'h0000_0000, 0);
      send_request(32'h0001_0000, 0);
      send_request(0, 1);
      send_request(32'h8000_0000, 0);
      send_request(32'h7FFF_FFFF, 0);
      while (grids_done == 0) send_request(0, 1);
      configure(0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      run_grid(0);
      configure(1, 1, 1, 5, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
      run_grid(20);

      // Random phases with idling on both sides.
      idle_on = 1;
      while (items_sent < 180) begin
         rm = $urandom_range(0, 1);
         rx = $urandom_range(0, 9);
         ry = $urandom_range(0, rm ? 4 : 8);
         rz = $urandom_range(0, 4);
         if (rm) rx = rx % 5;
         configure(rm, rx, ry, rz, pick_weight(), pick_weight(), pick_weight());
         run_grid($urandom_range(0, 25));
         // At random, hold the sender until every outstanding result has come back.
         if ($urandom_range(0, 3) == 0) begin
            end_requests();
            wait (pending == 0);
         end
      end

      // Largest extents, then a last stretch with no idling.
      configure(0, 127, 2, 0, pick_weight(), pick_weight(), 0);
      run_grid(5);
      configure(1, 1, 1, 64, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF);
      run_grid(5);
      configure(1, 64, 1, 2, 32'h0000_8000, 32'h0002_0000, 32'h0001_0000);
      run_grid(5);
      idle_on = 0;
      configure(0, 64, 1, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      run_grid(0);
      configure(1, 4, 3, 2, pick_weight(), pick_weight(), pick_weight());
      run_grid(0);
      end_requests();

      wait (pending == 0);
      repeat (200) @(posedge clock);
      $display("Sent %0d request items and checked %0d results over %0d grids.",
               items_sent, results_seen, grids_done);
      $display("Saturated results seen: %0d.", sat_seen);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/glss_pkg.sv
rtl/core/glss_ctrl.sv
rtl/core/glss_dpath.sv
rtl/core/grid_laplacian_squared_stencil.sv
tb/sv/glss_checker.sv
tb/sv/tb_top.sv
